### design/icmpnat_pkg.sv
package icmpnat_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic OP_SNAT = 1'b0;
    localparam logic OP_DNAT = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_ENTRY = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] icmp_ident;
        logic [31:0] packet_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] new_address;
        logic        status;
        logic        entry_added;
    } t_out_item;

    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] source;
    } t_entry;

endpackage

### design/icmp_nat_translation_table.sv
// ICMP NAT translation table
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one packet beat:
// op, ICMP identifier and address. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns one result beat per input beat, in order.
// i_cfg_we / i_cfg_wdata write the SNAT address; write only while idle.
//
// Each beat scans the entry memory one entry per cycle (the memory read is
// registered), stopping at the first valid match, then writes back at most one
// entry. A miss scans every entry and an early hit stops sooner; the scan runs
// over the single memory read port. One item is in work at a time, so the next
// beat is taken only once the last result has left the finish state.
//
// Reset clears the valid bits, the write pointer, the SNAT address and all
// handshake state; entry contents are left as they are and never match until
// written. A finished result sits in the output register while the next beat
// is accepted and scanned; when the receiver stalls, the next result waits in
// the finish state until the output register is free.
module icmp_nat_translation_table #(
    parameter int TABLE_ENTRIES = icmpnat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  icmpnat_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output icmpnat_pkg::t_out_item o_out_data,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_wdata
);
    import icmpnat_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state              r_state, n_state;
    t_in_item            r_item;
    logic [31:0]         r_snat;
    logic [CNT_W-1:0]    r_scan_cnt;
    logic                r_rd_pend;
    logic [IDX_W-1:0]    r_rd_idx;
    t_entry              r_rd_data;
    logic                r_hit;
    logic [31:0]         r_hit_src;
    logic [IDX_W-1:0]    r_wr_ptr;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                r_out_valid;
    t_out_item           r_out;

    t_entry              mem [TABLE_ENTRIES];

    logic                in_acc;
    logic                rd_issue;
    logic                hit_now;
    logic                out_free;
    logic                finish;
    logic                mem_we;
    t_out_item           res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign rd_issue    = (r_state == S_SCAN) && (r_scan_cnt != CNT_END);
    assign hit_now     = (r_state == S_SCAN) && r_rd_pend && r_valid[r_rd_idx]
                         && (r_rd_data.ident == r_item.icmp_ident);
    assign out_free    = !r_out_valid || i_out_ready;
    assign finish      = (r_state == S_FINISH) && out_free;
    assign mem_we      = finish && (r_item.op == OP_SNAT) && !r_hit;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        res = '0;
        if (r_item.op == OP_SNAT) begin
            res.new_address = r_snat;
            res.status      = ST_OK;
            res.entry_added = !r_hit;
        end else if (r_hit) begin
            res.new_address = r_hit_src;
            res.status      = ST_OK;
        end else begin
            res.new_address = r_item.packet_address;
            res.status      = ST_NO_ENTRY;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit_now || (!r_rd_pend && r_scan_cnt == CNT_END)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_ptr] <= '{ident: r_item.icmp_ident, source: r_item.packet_address};
        end
        r_rd_data <= mem[r_scan_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_snat      <= '0;
            r_scan_cnt  <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_wr_ptr    <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_snat <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_scan_cnt <= '0;
                r_rd_pend  <= 1'b0;
                r_hit      <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rd_pend <= rd_issue;
                if (rd_issue) begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (mem_we) begin
                r_valid[r_wr_ptr] <= 1'b1;
                r_wr_ptr <= (r_wr_ptr == IDX_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (rd_issue) begin
            r_rd_idx <= r_scan_cnt[IDX_W-1:0];
        end
        if (hit_now) begin
            r_hit_src <= r_rd_data.source;
        end
        if (finish) begin
            r_out <= res;
        end
    end

    a_added_only_outbound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_NO_ENTRY |-> !r_out.entry_added)
        else $error("no-entry result also reports an added entry");

    a_ptr_moves_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr != $past(r_wr_ptr) |-> $past(mem_we))
        else $error("write pointer moved without a table write");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_valid[$past(r_wr_ptr)])
        else $error("written entry not marked valid");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish state");

endmodule

### verif/icmp_nat_translation_table_test.sv
`timescale 1ns / 100ps

module icmp_nat_translation_table_test;

    import icmpnat_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES_DEF + 8;
    localparam int POOL_DEPTH = 24;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;
    logic      i_cfg_we;
    logic [31:0] i_cfg_wdata;

    // translation table as the block should hold it
    logic [15:0] nat_ident  [TABLE_ENTRIES_DEF];
    logic [31:0] nat_source [TABLE_ENTRIES_DEF];
    bit          nat_valid  [TABLE_ENTRIES_DEF];
    int unsigned nat_wr_ptr;
    logic [31:0] snat_addr;

    t_out_item   pending_translations[$];
    t_stim_row   directed_rows[$];
    logic [15:0] recent_idents[$];

    int  failures;
    int  idle_pct;
    int  stall_pct;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;

    icmp_nat_translation_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_out_item translate_packet(input t_in_item pkt);
        t_out_item res;
        int hit;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            if (hit < 0 && nat_valid[i] && nat_ident[i] == pkt.icmp_ident) begin
                hit = i;
            end
        end
        res = '0;
        if (pkt.op == OP_SNAT) begin
            res.new_address = snat_addr;
            res.status = ST_OK;
            if (hit < 0) begin
                nat_ident[nat_wr_ptr] = pkt.icmp_ident;
                nat_source[nat_wr_ptr] = pkt.packet_address;
                nat_valid[nat_wr_ptr] = 1'b1;
                nat_wr_ptr = (nat_wr_ptr + 1) % TABLE_ENTRIES_DEF;
                res.entry_added = 1'b1;
                recent_idents.push_back(pkt.icmp_ident);
                if (recent_idents.size() > POOL_DEPTH) begin
                    void'(recent_idents.pop_front());
                end
            end
        end else if (hit >= 0) begin
            res.new_address = nat_source[hit];
            res.status = ST_OK;
        end else begin
            res.new_address = pkt.packet_address;
            res.status = ST_NO_ENTRY;
        end
        return res;
    endfunction

    task automatic add_row(input logic op, input logic [15:0] ident, input logic [31:0] addr,
                           input bit typed, input logic [31:0] want_addr,
                           input logic want_status, input logic want_added);
        t_stim_row row;
        row.item.op = op;
        row.item.icmp_ident = ident;
        row.item.packet_address = addr;
        row.typed = typed;
        row.want.new_address = want_addr;
        row.want.status = want_status;
        row.want.entry_added = want_added;
        directed_rows.push_back(row);
    endtask

    // offer one beat, predict at the edge it is taken
    task automatic send_beat(input t_in_item pkt, input bit typed, input t_out_item want);
        t_out_item predicted;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= pkt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = translate_packet(pkt);
        pending_translations.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained;
        while (pending_translations.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int beats, input int idle, input int stall,
                             input logic [31:0] snat_value, input int hold_at);
        t_in_item pkt;
        int sel;
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= snat_value;
        snat_addr = snat_value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < beats; n++) begin
            pkt.op = $urandom_range(1) ? OP_DNAT : OP_SNAT;
            sel = $urandom_range(99);
            if (sel < 60 && recent_idents.size() != 0) begin
                pkt.icmp_ident = recent_idents[$urandom_range(recent_idents.size() - 1)];
            end else if (sel < 68) begin
                pkt.icmp_ident = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end else begin
                pkt.icmp_ident = 16'($urandom_range(16'hFFFF));
            end
            sel = $urandom_range(99);
            if (sel < 5) begin
                pkt.packet_address = 32'h0000_0000;
            end else if (sel < 10) begin
                pkt.packet_address = 32'hFFFF_FFFF;
            end else begin
                pkt.packet_address = $urandom;
            end
            send_beat(pkt, 1'b0, '0);
            if (n == hold_at) begin
                hold_req = 1'b1;
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial begin
        i_out_ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_translations.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, o_out_data);
                failures++;
            end else begin
                want = pending_translations.pop_front();
                if (o_out_data.new_address !== want.new_address) begin
                    $display("%0t: new_address expected %h actual %h", $realtime,
                             want.new_address, o_out_data.new_address);
                    failures++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %h actual %h", $realtime,
                             want.status, o_out_data.status);
                    failures++;
                end
                if (o_out_data.entry_added !== want.entry_added) begin
                    $display("%0t: entry_added expected %h actual %h", $realtime,
                             want.entry_added, o_out_data.entry_added);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("icmp_nat_translation_table test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        failures = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        nat_wr_ptr = 0;
        snat_addr = '0;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            nat_valid[i] = 1'b0;
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;

        // unwritten entries, key extremes, outbound hit, wrap-around eviction
        add_row(OP_DNAT, 16'h0000, 32'h1234_5678, 1'b1, 32'h1234_5678, ST_NO_ENTRY, 1'b0);
        add_row(OP_DNAT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_NO_ENTRY, 1'b0);
        add_row(OP_SNAT, 16'h0000, 32'h0A00_0001, 1'b1, 32'h0000_0000, ST_OK, 1'b1);
        add_row(OP_DNAT, 16'h0000, 32'h0000_0000, 1'b1, 32'h0A00_0001, ST_OK, 1'b0);
        add_row(OP_SNAT, 16'h0000, 32'hC0A8_0001, 1'b1, 32'h0000_0000, ST_OK, 1'b0);
        add_row(OP_DNAT, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'h0A00_0001, ST_OK, 1'b0);
        add_row(OP_SNAT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK, 1'b1);
        add_row(OP_DNAT, 16'hFFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK, 1'b0);
        add_row(OP_SNAT, 16'h8000, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 1'b1);
        add_row(OP_DNAT, 16'h8000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK, 1'b0);
        for (int k = 1; k <= 13; k++) begin
            add_row(OP_SNAT, 16'h0100 + 16'(k), {16'hAC10, 16'(k)}, 1'b0, '0, ST_OK, 1'b0);
        end
        add_row(OP_SNAT, 16'h0200, 32'h5555_AAAA, 1'b0, '0, ST_OK, 1'b0);
        add_row(OP_DNAT, 16'h0000, 32'hAAAA_5555, 1'b1, 32'hAAAA_5555, ST_NO_ENTRY, 1'b0);
        add_row(OP_DNAT, 16'h0200, 32'h0000_0000, 1'b0, '0, ST_OK, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_beat(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end
        i_in_valid <= 1'b0;

        run_phase(250, 0, 0, 32'hFFFF_FFFF, 100);
        run_phase(250, 64, 0, $urandom, -1);
        run_phase(250, 0, 64, 32'h0000_0000, -1);
        run_phase(275, 13, 13, $urandom, -1);

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("icmp_nat_translation_table test passed");
        end else begin
            $display("icmp_nat_translation_table test failed");
        end
        $finish;
    end

endmodule
